>>> rtl/core/tefr_pkg.sv
// Shared types and constants for the edge-function triangle rasterizer.
// No dependencies; imported by every module of the rasterizer core.
package tefr_pkg;

	localparam int COORD_BITS    = 16;
	localparam int MAX_FRAME_DIM = 4096;

	localparam int COORD_W   = 16;
	localparam int COORD_PAD = COORD_W - COORD_BITS;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int EDGE_W    = 36;
	localparam int FRAME_W   = 13;
	localparam int FIDX_W    = $clog2(MAX_FRAME_DIM);
	localparam int ADDR_W    = 24;
	localparam int COLOR_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [FRAME_W-1:0] FRAME_W_RST = FRAME_W'(640);
	localparam logic [FRAME_W-1:0] FRAME_H_RST = FRAME_W'(480);
	localparam logic [FRAME_W-1:0] FRAME_MAX   = FRAME_W'(MAX_FRAME_DIM);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR   = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		LD_IDLE,
		LD_MUL,
		LD_FIN
	} ld_state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [DIFF_W-1:0]  dx_a;
		logic signed [DIFF_W-1:0]  dx_b;
		logic signed [DIFF_W-1:0]  dx_c;
		logic signed [DIFF_W-1:0]  dy_a;
		logic signed [DIFF_W-1:0]  dy_b;
		logic signed [DIFF_W-1:0]  dy_c;
		logic signed [EDGE_W-1:0]  edge_a;
		logic signed [EDGE_W-1:0]  edge_b;
		logic signed [EDGE_W-1:0]  edge_c;
	} setup_t;

	typedef struct packed {
		logic              covered;
		logic              write_en;
		logic              end_row;
		logic [ADDR_W-1:0] addr;
	} pix_t;

	function automatic logic signed [COORD_W-1:0] coord_in(input logic [COORD_W-1:0] raw);
		logic [COORD_W-1:0] tmp;
		tmp = raw << COORD_PAD;
		return $signed(tmp) >>> COORD_PAD;
	endfunction

endpackage

>>> rtl/core/triangle_edge_function_rasterizer_core.sv
// Edge-function triangle rasterizer core: one box position per step while busy.
// Step: result registered on acceptance; one per cycle unless out_stall holds it.
// Load: no result; holds the input register through the differences, multiply and
// combine stages of tefr_setup, so the next transaction is taken after combine.
// Reset: idle, edge/cursor state zero, frame 640x480, draw color zero.
// Depends on tefr_pkg, tefr_setup, tefr_pixel.
module triangle_edge_function_rasterizer_core import tefr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic signed [COORD_W-1:0] vert1_x,
	input  logic signed [COORD_W-1:0] vert1_y,
	input  logic signed [COORD_W-1:0] vert2_x,
	input  logic signed [COORD_W-1:0] vert2_y,
	input  logic signed [COORD_W-1:0] vert3_x,
	input  logic signed [COORD_W-1:0] vert3_y,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] pos_x,
	output logic signed [COORD_W-1:0] pos_y,
	output logic                      write_enable,
	output logic [ADDR_W-1:0]         pixel_address,
	output logic [COLOR_W-1:0]        pixel_value,
	output logic                      last_position,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [COLOR_W-1:0]        cfg_data
);

	logic [FRAME_W-1:0] frame_width_q, frame_height_q;
	logic [COLOR_W-1:0] draw_color_q;

	logic                      valid_s1, cmd_s1;
	logic signed [COORD_W-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1;

	ld_state_t ld_state_q, ld_state_d;
	logic      ld_cap, ld_mul, ld_commit;

	logic signed [EDGE_W-1:0]  edge_row_a_q, edge_row_b_q, edge_row_c_q;
	logic signed [EDGE_W-1:0]  edge_cur_a_q, edge_cur_b_q, edge_cur_c_q;
	logic signed [DIFF_W-1:0]  dx_step_q [3];
	logic signed [DIFF_W-1:0]  dy_step_q [3];
	logic signed [COORD_W-1:0] cursor_x_q, cursor_y_q;
	logic signed [COORD_W-1:0] min_x_q, max_x_q, max_y_q;
	logic                      row_found_q, busy_q;

	logic   out_valid_q, out_free, step_go, fire, last;
	setup_t setup;
	pix_t   pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_W_RST;
			frame_height_q <= FRAME_H_RST;
			draw_color_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_W-1:0];
				CFG_DRAW_COLOR:   draw_color_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign step_go   = valid_s1 && (cmd_s1 == CMD_STEP) && busy_q && out_free;
	assign fire      = valid_s1 && (((cmd_s1 == CMD_STEP) && (!busy_q || out_free))
		|| ((cmd_s1 == CMD_LOAD) && ld_commit));
	assign in_stall  = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= command;
			x1_s1  <= coord_in(vert1_x);
			y1_s1  <= coord_in(vert1_y);
			x2_s1  <= coord_in(vert2_x);
			y2_s1  <= coord_in(vert2_y);
			x3_s1  <= coord_in(vert3_x);
			y3_s1  <= coord_in(vert3_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_state_q <= LD_IDLE;
		end else begin
			ld_state_q <= ld_state_d;
		end
	end

	always_comb begin
		ld_state_d = ld_state_q;
		ld_cap     = 1'b0;
		ld_mul     = 1'b0;
		ld_commit  = 1'b0;
		case (ld_state_q)
			LD_IDLE: begin
				if (valid_s1 && (cmd_s1 == CMD_LOAD)) begin
					ld_cap     = 1'b1;
					ld_state_d = LD_MUL;
				end
			end
			LD_MUL: begin
				ld_mul     = 1'b1;
				ld_state_d = LD_FIN;
			end
			LD_FIN: begin
				ld_commit  = 1'b1;
				ld_state_d = LD_IDLE;
			end
			default: ld_state_d = LD_IDLE;
		endcase
	end

	tefr_setup u_setup (
		.clk    (clk),
		.cap    (ld_cap),
		.mul_en (ld_mul),
		.x1     (x1_s1),
		.y1     (y1_s1),
		.x2     (x2_s1),
		.y2     (y2_s1),
		.x3     (x3_s1),
		.y3     (y3_s1),
		.res    (setup)
	);

	tefr_pixel u_pixel (
		.cur_x        (cursor_x_q),
		.cur_y        (cursor_y_q),
		.edge_a       (edge_cur_a_q),
		.edge_b       (edge_cur_b_q),
		.edge_c       (edge_cur_c_q),
		.max_x        (max_x_q),
		.row_found    (row_found_q),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pix          (pix)
	);

	assign last = pix.end_row && (cursor_y_q >= max_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_row_a_q <= '0;
			edge_row_b_q <= '0;
			edge_row_c_q <= '0;
			edge_cur_a_q <= '0;
			edge_cur_b_q <= '0;
			edge_cur_c_q <= '0;
			for (int i = 0; i < 3; i++) begin
				dx_step_q[i] <= '0;
				dy_step_q[i] <= '0;
			end
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			min_x_q     <= '0;
			max_x_q     <= '0;
			max_y_q     <= '0;
			row_found_q <= 1'b0;
			busy_q      <= 1'b0;
		end else if (ld_commit) begin
			edge_row_a_q <= setup.edge_a;
			edge_row_b_q <= setup.edge_b;
			edge_row_c_q <= setup.edge_c;
			edge_cur_a_q <= setup.edge_a;
			edge_cur_b_q <= setup.edge_b;
			edge_cur_c_q <= setup.edge_c;
			dx_step_q[0] <= setup.dx_a;
			dx_step_q[1] <= setup.dx_b;
			dx_step_q[2] <= setup.dx_c;
			dy_step_q[0] <= setup.dy_a;
			dy_step_q[1] <= setup.dy_b;
			dy_step_q[2] <= setup.dy_c;
			cursor_x_q   <= setup.min_x;
			cursor_y_q   <= setup.min_y;
			min_x_q      <= setup.min_x;
			max_x_q      <= setup.max_x;
			max_y_q      <= setup.max_y;
			row_found_q  <= 1'b0;
			busy_q       <= 1'b1;
		end else if (step_go) begin
			if (!pix.end_row) begin
				edge_cur_a_q <= edge_cur_a_q - EDGE_W'(dy_step_q[0]);
				edge_cur_b_q <= edge_cur_b_q - EDGE_W'(dy_step_q[1]);
				edge_cur_c_q <= edge_cur_c_q - EDGE_W'(dy_step_q[2]);
				cursor_x_q   <= cursor_x_q + COORD_W'(1);
				row_found_q  <= row_found_q || pix.covered;
			end else if (last) begin
				busy_q <= 1'b0;
			end else begin
				edge_row_a_q <= edge_row_a_q + EDGE_W'(dx_step_q[0]);
				edge_row_b_q <= edge_row_b_q + EDGE_W'(dx_step_q[1]);
				edge_row_c_q <= edge_row_c_q + EDGE_W'(dx_step_q[2]);
				edge_cur_a_q <= edge_row_a_q + EDGE_W'(dx_step_q[0]);
				edge_cur_b_q <= edge_row_b_q + EDGE_W'(dx_step_q[1]);
				edge_cur_c_q <= edge_row_c_q + EDGE_W'(dx_step_q[2]);
				cursor_x_q   <= min_x_q;
				cursor_y_q   <= cursor_y_q + COORD_W'(1);
				row_found_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step_go;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			pos_x         <= cursor_x_q;
			pos_y         <= cursor_y_q;
			write_enable  <= pix.write_en;
			pixel_address <= pix.addr;
			pixel_value   <= pix.write_en ? draw_color_q : '0;
			last_position <= last;
		end
	end

	assign out_valid = out_valid_q;

	a_load_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_state_q == LD_MUL) |-> in_stall)
		else $error("input taken while load setup in flight");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && last) |=> !busy_q)
		else $error("still busy after final position");

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_enable) |-> (pixel_address == '0 && pixel_value == '0))
		else $error("address or value set on unwritten position");

	a_cursor_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cursor_x_q <= max_x_q && cursor_y_q <= max_y_q))
		else $error("cursor left the bounding box");

endmodule

>>> rtl/core/tefr_setup.sv
// Triangle setup: bounding box, edge deltas and edge values at the box corner.
// Register stages for differences and products, then a combinational combine; uses tefr_pkg.
module tefr_setup import tefr_pkg::*; (
	input  logic                      clk,
	input  logic                      cap,
	input  logic                      mul_en,
	input  logic signed [COORD_W-1:0] x1,
	input  logic signed [COORD_W-1:0] y1,
	input  logic signed [COORD_W-1:0] x2,
	input  logic signed [COORD_W-1:0] y2,
	input  logic signed [COORD_W-1:0] x3,
	input  logic signed [COORD_W-1:0] y3,
	output setup_t                    res
);

	logic signed [COORD_W-1:0] mnx, mny, mxx, mxy;
	logic signed [COORD_W-1:0] mnx_q, mny_q, mxx_q, mxy_q;
	logic signed [DIFF_W-1:0]  dxa_q, dxb_q, dxc_q, dya_q, dyb_q, dyc_q;
	logic signed [DIFF_W-1:0]  pxa_q, pxb_q, pxc_q, pya_q, pyb_q, pyc_q;
	logic signed [PROD_W-1:0]  pa1_q, pa2_q, pb1_q, pb2_q, pc1_q, pc2_q, cr1_q, cr2_q;
	logic signed [PROD_W:0]    wind;
	logic signed [EDGE_W-1:0]  ea_p, ea_n, eb_p, eb_n, ec_p, ec_n;
	logic                      cw;

	always_comb begin
		mnx = (x1 < x2) ? x1 : x2;
		mnx = (mnx < x3) ? mnx : x3;
		mny = (y1 < y2) ? y1 : y2;
		mny = (mny < y3) ? mny : y3;
		mxx = (x1 > x2) ? x1 : x2;
		mxx = (mxx > x3) ? mxx : x3;
		mxy = (y1 > y2) ? y1 : y2;
		mxy = (mxy > y3) ? mxy : y3;
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			mnx_q <= mnx;
			mny_q <= mny;
			mxx_q <= mxx;
			mxy_q <= mxy;
			dxa_q <= DIFF_W'(x3) - DIFF_W'(x2);
			dya_q <= DIFF_W'(y3) - DIFF_W'(y2);
			dxb_q <= DIFF_W'(x1) - DIFF_W'(x3);
			dyb_q <= DIFF_W'(y1) - DIFF_W'(y3);
			dxc_q <= DIFF_W'(x2) - DIFF_W'(x1);
			dyc_q <= DIFF_W'(y2) - DIFF_W'(y1);
			pxa_q <= DIFF_W'(mnx) - DIFF_W'(x2);
			pya_q <= DIFF_W'(mny) - DIFF_W'(y2);
			pxb_q <= DIFF_W'(mnx) - DIFF_W'(x3);
			pyb_q <= DIFF_W'(mny) - DIFF_W'(y3);
			pxc_q <= DIFF_W'(mnx) - DIFF_W'(x1);
			pyc_q <= DIFF_W'(mny) - DIFF_W'(y1);
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			pa1_q <= PROD_W'(dxa_q) * PROD_W'(pya_q);
			pa2_q <= PROD_W'(dya_q) * PROD_W'(pxa_q);
			pb1_q <= PROD_W'(dxb_q) * PROD_W'(pyb_q);
			pb2_q <= PROD_W'(dyb_q) * PROD_W'(pxb_q);
			pc1_q <= PROD_W'(dxc_q) * PROD_W'(pyc_q);
			pc2_q <= PROD_W'(dyc_q) * PROD_W'(pxc_q);
			cr1_q <= PROD_W'(dxc_q) * PROD_W'(dya_q);
			cr2_q <= PROD_W'(dxa_q) * PROD_W'(dyc_q);
		end
	end

	// clockwise winding swaps v2/v3: A -> -A, B -> -C, C -> -B
	always_comb begin
		wind  = (PROD_W+1)'(cr1_q) - (PROD_W+1)'(cr2_q);
		cw    = wind[PROD_W];
		ea_p  = EDGE_W'(pa1_q) - EDGE_W'(pa2_q);
		ea_n  = EDGE_W'(pa2_q) - EDGE_W'(pa1_q);
		eb_p  = EDGE_W'(pb1_q) - EDGE_W'(pb2_q);
		eb_n  = EDGE_W'(pb2_q) - EDGE_W'(pb1_q);
		ec_p  = EDGE_W'(pc1_q) - EDGE_W'(pc2_q);
		ec_n  = EDGE_W'(pc2_q) - EDGE_W'(pc1_q);

		res.min_x = mnx_q;
		res.min_y = mny_q;
		res.max_x = mxx_q;
		res.max_y = mxy_q;
		if (cw) begin
			res.edge_a = ea_n;
			res.edge_b = ec_n;
			res.edge_c = eb_n;
			res.dx_a   = -dxa_q;
			res.dx_b   = -dxc_q;
			res.dx_c   = -dxb_q;
			res.dy_a   = -dya_q;
			res.dy_b   = -dyc_q;
			res.dy_c   = -dyb_q;
		end else begin
			res.edge_a = ea_p;
			res.edge_b = eb_p;
			res.edge_c = ec_p;
			res.dx_a   = dxa_q;
			res.dx_b   = dxb_q;
			res.dx_c   = dxc_q;
			res.dy_a   = dya_q;
			res.dy_b   = dyb_q;
			res.dy_c   = dyc_q;
		end
	end

endmodule

>>> rtl/core/tefr_pixel.sv
// Per-position evaluation: coverage, frame clipping, row end and address.
// Purely combinational; uses tefr_pkg.
module tefr_pixel import tefr_pkg::*; (
	input  logic signed [COORD_W-1:0] cur_x,
	input  logic signed [COORD_W-1:0] cur_y,
	input  logic signed [EDGE_W-1:0]  edge_a,
	input  logic signed [EDGE_W-1:0]  edge_b,
	input  logic signed [EDGE_W-1:0]  edge_c,
	input  logic signed [COORD_W-1:0] max_x,
	input  logic                      row_found,
	input  logic [FRAME_W-1:0]        frame_width,
	input  logic [FRAME_W-1:0]        frame_height,
	output pix_t                      pix
);

	logic [FRAME_W-1:0]        fw, fh;
	logic [COORD_W-1:0]        ux, uy;
	logic                      in_frame, at_max;
	logic [FIDX_W+FRAME_W-1:0] yw, sum;

	always_comb begin
		fw       = (frame_width > FRAME_MAX) ? FRAME_MAX : frame_width;
		fh       = (frame_height > FRAME_MAX) ? FRAME_MAX : frame_height;
		ux       = cur_x;
		uy       = cur_y;
		in_frame = !cur_x[COORD_W-1] && !cur_y[COORD_W-1]
			&& (ux < COORD_W'(fw)) && (uy < COORD_W'(fh));
		at_max   = (cur_x == max_x);

		pix.covered  = !edge_a[EDGE_W-1] && !edge_b[EDGE_W-1] && !edge_c[EDGE_W-1];
		pix.write_en = pix.covered && in_frame;
		pix.end_row  = pix.covered ? at_max : (row_found || at_max);

		yw  = (FIDX_W+FRAME_W)'(uy[FIDX_W-1:0]) * (FIDX_W+FRAME_W)'(fw);
		sum = yw + (FIDX_W+FRAME_W)'(ux[FIDX_W-1:0]);
		pix.addr = pix.write_en ? sum[ADDR_W-1:0] : '0;
	end

endmodule
